### rtl/xsph_pkg.sv
// Shared types and constants of the XSPH velocity smoothing block.
// No dependencies; xsph_front, xsph_back, xsph_velocity_smoothing and the testbench import this package.
`default_nettype none

package xsph_pkg;

  localparam int POS_W     = 32;
  localparam int VEL_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int RSQ_W     = 40;
  localparam int SHIFT_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int NEAR_W    = 20;
  localparam int R2_W      = 42;
  localparam int VD_W      = 33;
  localparam int CORR_W    = 34;
  localparam int GAIN_FRAC = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN         = 2'd0,
    REG_RADIUS_SQ    = 2'd1,
    REG_WEIGHT_SHIFT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_OWN   = 3'b001,
    OP_NEIGH = 3'b010,
    OP_SKIP  = 3'b100
  } op_t;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic              is_self;
    logic              last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } result_t;

  typedef struct packed {
    op_t                   op;
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][VEL_W-1:0] vel;
    logic                  last;
  } entry_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [RSQ_W-1:0]   radius_sq;
    logic [SHIFT_W-1:0] weight_shift;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/xsph_stream_if.sv
// Valid/ready stream channel carrying one word of a given type.
// No dependencies; the word type is set where the channel is instantiated.
`default_nettype none

interface xsph_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/xsph_front.sv
// Front end: accepts input words, classifies them and holds them in a short queue.
// Depends on xsph_pkg and xsph_stream_if.
`default_nettype none

module xsph_front (
  input  wire logic   clk,
  input  wire logic   rst,
  xsph_stream_if.sink   item,
  xsph_stream_if.source queue_out
);
  import xsph_pkg::*;

  localparam int DEPTH = 2;

  entry_t     mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  entry_t     incoming;
  logic       push;
  logic       pop;

  always_comb begin
    if (!item.data.kind) begin
      incoming.op = OP_OWN;
    end else if (item.data.is_self) begin
      incoming.op = OP_SKIP;
    end else begin
      incoming.op = OP_NEIGH;
    end
    incoming.pos  = {item.data.pos_z, item.data.pos_y, item.data.pos_x};
    incoming.vel  = {item.data.vel_z, item.data.vel_y, item.data.vel_x};
    incoming.last = item.data.last;
  end

  assign item.ready      = (count != 2'(DEPTH));
  assign push            = item.valid && item.ready;
  assign queue_out.valid = (count != 2'd0);
  assign queue_out.data  = mem[rd_ptr];
  assign pop             = queue_out.valid && queue_out.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/xsph_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none

module xsph_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 23
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### rtl/xsph_back.sv
// Back end: weights neighbours, accumulates the sums and forms the smoothed velocity.
// Depends on xsph_pkg, xsph_stream_if and xsph_div.
`default_nettype none

module xsph_back #(
  parameter int MAX_NEIGHBORS = 64,
  parameter int WEIGHT_BITS   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire xsph_pkg::cfg_t cfg,
  xsph_stream_if.sink        queue_in,
  xsph_stream_if.source      result
);
  import xsph_pkg::*;

  localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int WT_W   = WEIGHT_BITS + CNT_W;
  localparam int SUM_W  = VD_W + WEIGHT_BITS + CNT_W;
  localparam int PRD_W  = VD_W + WEIGHT_BITS + 1;
  localparam int SCL_W  = CORR_W + GAIN_W + 1;
  localparam int APP_W  = SCL_W + 1;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_SQUARE    = 11'b00000000010,
    S_RANGE     = 11'b00000000100,
    S_CUBE      = 11'b00000001000,
    S_WEIGHT    = 11'b00000010000,
    S_ACCUM     = 11'b00000100000,
    S_DIV_START = 11'b00001000000,
    S_DIV_WAIT  = 11'b00010000000,
    S_SCALE     = 11'b00100000000,
    S_APPLY     = 11'b01000000000,
    S_OUT       = 11'b10000000000
  } state_t;

  state_t state;

  logic [2:0][POS_W-1:0]   own_pos;
  logic [2:0][VEL_W-1:0]   own_vel;
  logic signed [SUM_W-1:0] wsum [3];
  logic [WT_W-1:0]         wtotal;
  logic [CNT_W-1:0]        ncount;

  logic                       last_q;
  logic                       skip_q;
  logic [NEAR_W-1:0]          absd [3];
  logic signed [VD_W-1:0]     vd [3];
  logic [R2_W-1:0]            r2;
  logic [WEIGHT_BITS-1:0]     s_q;
  logic [2*WEIGHT_BITS-1:0]   ss;
  logic [WEIGHT_BITS-1:0]     w_q;
  logic [1:0]                 axis;
  logic signed [CORR_W-1:0]   corr;
  logic signed [SCL_W-1:0]    prod;
  logic [2:0][VEL_W-1:0]      res;
  logic                       out_valid;
  result_t                    out_data;

  logic signed [VD_W-1:0]     pdiff [3];
  logic [VD_W-1:0]            pabs [3];
  logic signed [VD_W-1:0]     vdiff [3];
  logic                       far;
  logic [RSQ_W-1:0]           margin;
  logic [RSQ_W-1:0]           scaled;
  logic [3*WEIGHT_BITS-1:0]   cube;
  logic signed [PRD_W-1:0]    contrib [3];
  logic                       div_start;
  logic [SUM_W-1:0]           div_num;
  logic                       div_done;
  logic [SUM_W-1:0]           div_quo;
  logic [CORR_W-1:0]          q_low;
  logic signed [APP_W-1:0]    term;
  logic signed [APP_W-1:0]    vsum;
  logic [VEL_W-1:0]           vsat;
  logic                       accept;
  logic                       out_free;

  assign accept   = queue_in.valid && queue_in.ready;
  assign out_free = !out_valid || result.ready;
  assign queue_in.ready = (state == S_IDLE);
  assign result.valid   = out_valid;
  assign result.data    = out_data;

  always_comb begin
    far = (ncount >= CNT_W'(MAX_NEIGHBORS));
    for (int k = 0; k < 3; k++) begin
      pdiff[k] = $signed({own_pos[k][POS_W-1], own_pos[k]})
               - $signed({queue_in.data.pos[k][POS_W-1], queue_in.data.pos[k]});
      pabs[k]  = pdiff[k][VD_W-1] ? VD_W'(-pdiff[k]) : VD_W'(pdiff[k]);
      far      = far || (pabs[k][VD_W-1:NEAR_W] != '0);
      vdiff[k] = $signed({queue_in.data.vel[k][VEL_W-1], queue_in.data.vel[k]})
               - $signed({own_vel[k][VEL_W-1], own_vel[k]});
    end
  end

  always_comb begin
    margin = cfg.radius_sq - r2[RSQ_W-1:0];
    scaled = margin >> cfg.weight_shift;
    cube   = ss * s_q;
    for (int k = 0; k < 3; k++) begin
      contrib[k] = vd[k] * $signed({1'b0, w_q});
    end
  end

  assign div_start = (state == S_DIV_START) && (wtotal != '0);
  assign div_num   = wsum[axis][SUM_W-1] ? SUM_W'(-wsum[axis]) : SUM_W'(wsum[axis]);
  assign q_low     = div_quo[CORR_W-1:0];

  xsph_div #(
    .NUM_W(SUM_W),
    .DEN_W(WT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (wtotal),
    .done (div_done),
    .quo  (div_quo)
  );

  always_comb begin
    term = (APP_W'(prod) + (prod[SCL_W-1] ? APP_W'((1 << GAIN_FRAC) - 1) : APP_W'(0)))
           >>> GAIN_FRAC;
    vsum = APP_W'($signed(own_vel[axis])) + term;
    if (vsum > APP_W'(32'sh7FFFFFFF)) begin
      vsat = 32'h7FFFFFFF;
    end else if (vsum < -APP_W'(33'sh80000000)) begin
      vsat = 32'h80000000;
    end else begin
      vsat = vsum[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      own_pos   <= '0;
      own_vel   <= '0;
      wsum      <= '{default: '0};
      wtotal    <= '0;
      ncount    <= '0;
      axis      <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= queue_in.data.last;
            axis   <= 2'd0;
            unique case (queue_in.data.op)
              OP_OWN: begin
                own_pos <= queue_in.data.pos;
                own_vel <= queue_in.data.vel;
                wsum    <= '{default: '0};
                wtotal  <= '0;
                ncount  <= '0;
                state   <= queue_in.data.last ? S_DIV_START : S_IDLE;
              end
              OP_NEIGH: begin
                skip_q <= far;
                for (int k = 0; k < 3; k++) begin
                  absd[k] <= pabs[k][NEAR_W-1:0];
                  vd[k]   <= vdiff[k];
                end
                state <= S_SQUARE;
              end
              OP_SKIP: begin
                state <= queue_in.data.last ? S_DIV_START : S_IDLE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SQUARE: begin
          r2 <= R2_W'(absd[0]) * R2_W'(absd[0]) + R2_W'(absd[1]) * R2_W'(absd[1])
              + R2_W'(absd[2]) * R2_W'(absd[2]);
          state <= S_RANGE;
        end
        S_RANGE: begin
          if (skip_q || (r2 > R2_W'(cfg.radius_sq))) begin
            state <= last_q ? S_DIV_START : S_IDLE;
          end else begin
            s_q   <= (scaled[RSQ_W-1:WEIGHT_BITS] != '0) ? '1 : scaled[WEIGHT_BITS-1:0];
            state <= S_CUBE;
          end
        end
        S_CUBE: begin
          ss    <= s_q * s_q;
          state <= S_WEIGHT;
        end
        S_WEIGHT: begin
          w_q   <= cube[3*WEIGHT_BITS-1:2*WEIGHT_BITS];
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          for (int k = 0; k < 3; k++) begin
            wsum[k] <= wsum[k] + SUM_W'(contrib[k]);
          end
          wtotal <= wtotal + WT_W'(w_q);
          ncount <= ncount + CNT_W'(1);
          state  <= last_q ? S_DIV_START : S_IDLE;
        end
        S_DIV_START: begin
          if (wtotal == '0) begin
            corr  <= '0;
            state <= S_SCALE;
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            corr  <= wsum[axis][SUM_W-1] ? -$signed(q_low) : $signed(q_low);
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod  <= $signed({1'b0, cfg.gain}) * corr;
          state <= S_APPLY;
        end
        S_APPLY: begin
          res[axis] <= vsat;
          if (axis == 2'd2) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_DIV_START;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data  <= {res[0], res[1], res[2]};
            wsum      <= '{default: '0};
            wtotal    <= '0;
            ncount    <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The neighbour count never passes the group limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    ncount <= CNT_W'(MAX_NEIGHBORS))
    else $error("neighbour count above limit");

  // Accumulating a neighbour never shrinks the weight total.
  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCUM) |=> (wtotal >= $past(wtotal)))
    else $error("weight total decreased on accumulate");

  // A new result word always leaves the sums cleared behind it.
  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (wtotal == '0) && (ncount == '0))
    else $error("sums not cleared after result");
`endif

endmodule

`default_nettype wire

### rtl/xsph_velocity_smoothing.sv
// XSPH velocity smoothing: a particle's own word opens a group, each neighbour
// word in range adds a poly6-shaped weight, and the last word of the group
// yields one word with the smoothed velocity. Depends on xsph_pkg,
// xsph_stream_if, xsph_front and xsph_back.
//
// A two-word queue separates the front end, which takes one word a cycle while
// the queue has room, from the back end, which handles one word at a time: an
// own word or a flagged neighbour is taken in the idle state alone, a neighbour
// out of range also passes the square and range steps, and one that is weighted
// passes the square, range, cube, weight and accumulate steps. When the weight
// total is non-zero, the last word of a group runs the one-bit-a-cycle divider
// once for each axis on a SUM_W-bit dividend, SUM_W being
// 33 + WEIGHT_BITS + clog2(MAX_NEIGHBORS + 1). A finished result waits in an
// output register while the back end goes on; the back end stalls only when a
// second result is ready before the first has been taken.
`default_nettype none

module xsph_velocity_smoothing #(
  parameter int MAX_NEIGHBORS = 64,
  parameter int WEIGHT_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [xsph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [xsph_pkg::RSQ_W-1:0]     cfg_data,
  xsph_stream_if.sink                        item,
  xsph_stream_if.source                      result
);
  import xsph_pkg::*;

  cfg_t cfg;

  xsph_stream_if #(.word_t(entry_t)) queue_link ();

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN:         cfg.gain         <= cfg_data[GAIN_W-1:0];
        REG_RADIUS_SQ:    cfg.radius_sq    <= cfg_data[RSQ_W-1:0];
        REG_WEIGHT_SHIFT: cfg.weight_shift <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  xsph_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .queue_out(queue_link)
  );

  xsph_back #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .queue_in(queue_link),
    .result  (result)
  );

endmodule

`default_nettype wire

### bench/xsph_velocity_smoothing_tb.sv
// Self-checking testbench of the XSPH velocity smoothing block.
// Predicts each smoothed velocity word and compares it with the block's output.
// Depends on xsph_pkg, xsph_stream_if and the RTL of xsph_velocity_smoothing.
`default_nettype none

module xsph_velocity_smoothing_tb;
  import xsph_pkg::*;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RSQ_W-1:0] cfg_data;

  xsph_stream_if #(.word_t(item_t)) item_ch ();
  xsph_stream_if #(.word_t(result_t)) res_ch ();

  xsph_velocity_smoothing dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(item_ch), .result(res_ch)
  );

  // Copy of the block's registers and state.
  logic [GAIN_W-1:0] gain_q;
  logic [RSQ_W-1:0] rsq_q;
  logic [SHIFT_W-1:0] shift_q;
  longint own_pos[3], own_vel[3], wsum[3];
  longint wtot;
  int nbr_count;

  item_t pending_words[$];
  result_t smoothed_due[$];
  int errors, accepted_words, results_seen, phase_no, off_max;
  int burst_left, gap_left, hold_cnt, stall_pct, stall_timer;
  bit long_hold_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic smooth_predict(item_t it);
    longint p[3], v[3], diff, a, r2, vd, corr, term;
    logic [63:0] d, s, w;
    result_t r;
    bit skip;
    p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
    v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
    if (!it.kind) begin
      for (int k = 0; k < 3; k++) begin
        own_pos[k] = p[k];
        own_vel[k] = v[k];
        wsum[k] = 0;
      end
      wtot = 0;
      nbr_count = 0;
    end else if (!it.is_self && nbr_count < 64) begin
      skip = 0;
      r2 = 0;
      for (int k = 0; k < 3; k++) begin
        diff = own_pos[k] - p[k];
        a = diff < 0 ? -diff : diff;
        if (a >= (64'sd1 << 20)) skip = 1;
        else r2 += a * a;
      end
      if (!skip && r2 <= longint'(rsq_q)) begin
        d = longint'(rsq_q) - r2;
        s = d >> shift_q;
        if (s > 64'd65535) s = 64'd65535;
        w = (s * s * s) >> 32;
        for (int k = 0; k < 3; k++) begin
          vd = v[k] - own_vel[k];
          wsum[k] += vd * longint'(w);
        end
        wtot += longint'(w);
        nbr_count++;
      end
    end
    if (it.last) begin
      for (int k = 0; k < 3; k++) begin
        corr = wtot > 0 ? wsum[k] / wtot : 0;
        term = (longint'(gain_q) * corr) / 4096;
        v[k] = clamp32(own_vel[k] + term);
        wsum[k] = 0;
      end
      wtot = 0;
      nbr_count = 0;
      r.new_vel_x = v[0][31:0];
      r.new_vel_y = v[1][31:0];
      r.new_vel_z = v[2][31:0];
      smoothed_due.push_back(r);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        smooth_predict(item_ch.data);
        accepted_words++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          item_ch.data <= pending_words.pop_front();
          item_ch.valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes at random times, plus one
  // long hold-off while the sender keeps offering words.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_pct = 0;
      stall_timer = 0;
      hold_cnt = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (smoothed_due.size() == 0) begin
          report("unexpected result word", res_ch.data.new_vel_x, 0);
        end else begin
          result_t want;
          want = smoothed_due.pop_front();
          if (res_ch.data.new_vel_x !== want.new_vel_x)
            report("new_vel_x", res_ch.data.new_vel_x, want.new_vel_x);
          if (res_ch.data.new_vel_y !== want.new_vel_y)
            report("new_vel_y", res_ch.data.new_vel_y, want.new_vel_y);
          if (res_ch.data.new_vel_z !== want.new_vel_z)
            report("new_vel_z", res_ch.data.new_vel_z, want.new_vel_z);
        end
      end
      if (phase_no == 1 && !long_hold_done) begin
        long_hold_done = 1;
        hold_cnt = 600;
      end
      if (stall_timer == 0) begin
        stall_timer = $urandom_range(50, 300);
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      stall_timer--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic item_t make_word(bit kind, int px, int py, int pz,
                                      int vx, int vy, int vz, bit self_flag, bit last);
    item_t it;
    it.kind = kind;
    it.pos_x = px; it.pos_y = py; it.pos_z = pz;
    it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
    it.is_self = self_flag;
    it.last = last;
    return it;
  endfunction

  function automatic int near_offset();
    if ($urandom_range(9) == 0) return $urandom_range(1 << 21, 1 << 20);
    return $urandom_range(2 * off_max) - off_max;
  endfunction

  function automatic int near_vel(int base);
    if ($urandom_range(1)) return $urandom;
    return base + $urandom_range(1 << 20) - (1 << 19);
  endfunction

  task automatic queue_group(int n);
    int p[3], v[3];
    for (int k = 0; k < 3; k++) begin
      p[k] = $urandom_range(1) ? $urandom : $urandom_range(1 << 24) - (1 << 23);
      v[k] = $urandom;
    end
    pending_words.push_back(make_word(0, p[0], p[1], p[2], v[0], v[1], v[2],
                                      1'($urandom_range(1)), n == 0));
    for (int i = 0; i < n; i++)
      pending_words.push_back(make_word(1, p[0] + near_offset(), p[1] + near_offset(),
                                        p[2] + near_offset(), near_vel(v[0]),
                                        near_vel(v[1]), near_vel(v[2]),
                                        $urandom_range(9) == 0, i == n - 1));
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || item_ch.valid || smoothed_due.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] g, logic [39:0] r, logic [5:0] sh);
    @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= REG_GAIN; cfg_data <= 40'(g);
    @(posedge clk);
    cfg_index <= REG_RADIUS_SQ; cfg_data <= r;
    @(posedge clk);
    cfg_index <= REG_WEIGHT_SHIFT; cfg_data <= 40'(sh);
    @(posedge clk);
    cfg_write <= 1'b0;
    gain_q = g; rsq_q = r; shift_q = sh;
    off_max = 1;
    while (off_max < (1 << 19) && 3.0 * (2.0 * off_max) * (2.0 * off_max) <= r)
      off_max = off_max * 2;
  endtask

  initial begin
    logic [15:0] gains[7] = '{16'hFFFF, 16'd4096, 16'd0, 16'd1234, 16'hFFFF, 16'd2048,
                              16'd0};
    logic [39:0] radii[7] = '{40'hFF_FFFF_FFFF, 40'd1 << 30, 40'd1 << 30, 40'd1 << 20,
                              40'd0, 40'd1 << 36, 40'd0};
    logic [5:0] shifts[7] = '{6'd24, 6'd14, 6'd14, 6'd4, 6'd0, 6'd63, 6'd0};
    int queued;
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    item_ch.valid = 1'b0; item_ch.data = '0; res_ch.ready = 1'b0;
    errors = 0; accepted_words = 0; results_seen = 0; phase_no = 0;
    gain_q = '0; rsq_q = '0; shift_q = '0; wtot = 0; nbr_count = 0;
    for (int k = 0; k < 3; k++) begin
      own_pos[k] = 0; own_vel[k] = 0; wsum[k] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    configure(gains[0], radii[0], shifts[0]);

    // Directed words: neighbours before any own word, field extremes, self and
    // distant neighbours, an own word that closes its group, a kept own word.
    pending_words.push_back(make_word(1, 0, 0, 0, 32'h7FFFFFFF, 0, 32'h80000000, 0, 0));
    pending_words.push_back(make_word(1, 5, -5, 3, 32'h80000000, 32'h7FFFFFFF, -1, 0, 1));
    pending_words.push_back(make_word(0, 32'h80000000, 32'h7FFFFFFF, -1,
                                      32'h7FFFFFFF, 32'h80000000, 0, 1, 1));
    pending_words.push_back(make_word(0, 1000, 2000, -3000, 100, -200, 300, 0, 0));
    pending_words.push_back(make_word(1, 1000, 2000, -3000, 999, 999, 999, 1, 0));
    pending_words.push_back(make_word(1, 1000 + (1 << 20), 2000, -3000, 7, 7, 7, 0, 0));
    pending_words.push_back(make_word(1, 1000, 2000, -3000, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0));
    pending_words.push_back(make_word(1, 1010, 1990, -3000, 32'h80000000,
                                      32'h80000000, 32'h80000000, 0, 1));
    pending_words.push_back(make_word(1, 1001, 2001, -2999, 5000, -5000, 0, 0, 1));
    pending_words.push_back(make_word(1, 32'h7FFFFFFF, 32'h80000000, 0, 1, 2, 3, 0, 1));
    queue_group(70);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_idle();
        phase_no = ph;
        if (ph == 6) configure(16'($urandom), 40'({$urandom, $urandom}),
                               6'($urandom_range(40)));
        else configure(gains[ph], radii[ph], shifts[ph]);
      end
      queued = 0;
      while (queued < 260) begin
        int n;
        if ($urandom_range(99) < 12) begin
          pending_words.push_back(make_word(1'($urandom), $urandom, $urandom, $urandom,
                                            $urandom, $urandom, $urandom,
                                            1'($urandom), 1'($urandom)));
          queued++;
        end else begin
          n = ($urandom_range(40) == 0) ? $urandom_range(65, 72) : $urandom_range(0, 8);
          queue_group(n);
          queued += n + 1;
        end
      end
    end
    wait_idle();
    $display("tb: %0d words accepted and %0d results checked over 7 register settings",
             accepted_words, results_seen);
    $display("tb: %0d mismatches", errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/xsph_pkg.sv
rtl/xsph_stream_if.sv
rtl/xsph_front.sv
rtl/xsph_div.sv
rtl/xsph_back.sv
rtl/xsph_velocity_smoothing.sv
bench/xsph_velocity_smoothing_tb.sv
